// File: src/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg
// shared types and constants for the riff/wave header parser
// ----------------------------------------------------------------------------
package rwhp_pkg;

    // chunk and header identifiers, big-endian as shifted in
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_READ_BYTES = 32'd16;
    localparam logic [31:0] HEADER_BYTES   = 32'd12;

    // status codes
    localparam logic [2:0] ST_PARSING = 3'd0;
    localparam logic [2:0] ST_IN_DATA = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_BAD_HDR = 3'd3;
    localparam logic [2:0] ST_NO_DATA = 3'd4;

    // one queued input byte
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic        data_valid;
        logic [7:0]  data_out;
        logic        data_last;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } result_t;

endpackage

// File: src/riff_wave_header_parser_core.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser_core
// byte-stream riff/wave header parser with data-chunk pass-through
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one byte of the wav file per
//   transaction, with end_of_stream high on the final byte of the file.
//   output channel (out_valid/out_ready) gives exactly one result per input
//   byte: parse status, the data byte when inside the data chunk (with
//   data_last), and the fmt fields and data length read so far.
//   a result is registered: its byte waits in the input queue, then
//   the parser step loads the output register once that register is
//   empty or its result is being taken.
//   throughput: one byte per cycle while the receiver takes results;
//   the input queue keeps taking bytes while a result waits to be taken.
//   receiver stall: the output register holds, the parser stops popping,
//   and the queue fills; in_ready drops once the queue is full.
//   reset: parser back to the riff header phase, all fields zero, queue
//   and output register empty.
//   after status finished, bad header or no data, further bytes only repeat
//   the last status and fields.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        data_valid,
    output logic [7:0]  data_out,
    output logic        data_last,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [15:0] sample_bits,
    output logic [31:0] data_length
);

    // front: input queue
    rwhp_pkg::item_t   in_item;
    rwhp_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_pop;
    rwhp_pkg::result_t res;

    assign in_item.data = in_byte;
    assign in_item.eos  = end_of_stream;

    rwhp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (in_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // back: parser and output register
    rwhp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign status        = res.status;
    assign data_valid    = res.data_valid;
    assign data_out      = res.data_out;
    assign data_last     = res.data_last;
    assign channel_count = res.channel_count;
    assign sample_rate   = res.sample_rate;
    assign sample_bits   = res.sample_bits;
    assign data_length   = res.data_length;

    // data_last only ever marks a real data byte
    a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_last |-> data_valid)
        else $error("data_last without data_valid");

    // a data byte comes out only while in data or on the finishing byte
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |->
            (status == rwhp_pkg::ST_IN_DATA) || (status == rwhp_pkg::ST_DONE))
        else $error("data byte outside data chunk");

    // finished is terminal
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (status == rwhp_pkg::ST_DONE) |=>
            !out_valid || ((status == rwhp_pkg::ST_DONE) && !data_valid))
        else $error("parser left finished state");

endmodule

// File: src/rwhp_fifo.sv
// ----------------------------------------------------------------------------
// rwhp_fifo
// short queue between the input side and the parser
// ----------------------------------------------------------------------------
module rwhp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rwhp_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output rwhp_pkg::item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rwhp_pkg::item_t slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/rwhp_parse.sv
// ----------------------------------------------------------------------------
// rwhp_parse
// byte-serial riff/wave parser with registered result stage
// ----------------------------------------------------------------------------
module rwhp_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  rwhp_pkg::item_t  item,
    output logic             item_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output rwhp_pkg::result_t res
);

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_FMT_HDR  = 4'd1,
        PH_SKIP_PRE = 4'd2,
        PH_FMT_BODY = 4'd3,
        PH_SKIP_FMT = 4'd4,
        PH_DATA_HDR = 4'd5,
        PH_SKIP_MID = 4'd6,
        PH_DATA     = 4'd7,
        PH_DONE     = 4'd8,
        PH_BAD      = 4'd9,
        PH_NODATA   = 4'd10
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic        bad_reg, bad_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] len_reg, len_next;
    logic        res_valid_reg, res_valid_next;
    rwhp_pkg::result_t res_reg, res_next;

    logic [7:0]  b;
    logic        dvalid, dlast;
    logic [7:0]  dout;
    logic [31:0] hdr_id, hdr_size;
    logic        hdr_done;
    logic [2:0]  st;

    assign b         = item.data;
    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // chunk header shifting shared by both header phases
    assign hdr_id   = (fc_reg < 32'd4) ? {id_reg[23:0], b} : id_reg;
    assign hdr_size = (fc_reg < 32'd4) ? size_reg : {b, size_reg[31:8]};
    assign hdr_done = (fc_reg >= 32'd7);

    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        bad_next   = bad_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        len_next   = len_reg;
        dvalid     = 1'b0;
        dout       = 8'd0;
        dlast      = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                id_next = {id_reg[23:0], b};
                if (fc_reg == 32'd3 && id_next != rwhp_pkg::ID_RIFF)
                begin
                    bad_next = 1'b1;
                end
                if (fc_reg >= rwhp_pkg::HEADER_BYTES - 32'd1)
                begin
                    if (id_next != rwhp_pkg::ID_WAVE)
                    begin
                        bad_next = 1'b1;
                    end
                    fc_next    = 32'd0;
                    phase_next = bad_next ? PH_BAD : PH_FMT_HDR;
                end
                else
                begin
                    fc_next = fc_reg + 32'd1;
                end
            end
            PH_FMT_HDR, PH_DATA_HDR:
            begin
                id_next   = hdr_id;
                size_next = hdr_size;
                fc_next   = fc_reg + 32'd1;
                if (hdr_done)
                begin
                    fc_next = 32'd0;
                    if (phase_reg == PH_FMT_HDR)
                    begin
                        if (hdr_id == rwhp_pkg::ID_FMT)
                        begin
                            phase_next = PH_FMT_BODY;
                        end
                        else if (hdr_size != 32'd0)
                        begin
                            phase_next = PH_SKIP_PRE;
                            fc_next    = hdr_size;
                        end
                    end
                    else if (hdr_id == rwhp_pkg::ID_DATA)
                    begin
                        len_next = hdr_size;
                        if (hdr_size == 32'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            fc_next    = hdr_size;
                        end
                    end
                    else if (hdr_size != 32'd0)
                    begin
                        phase_next = PH_SKIP_MID;
                        fc_next    = hdr_size;
                    end
                end
            end
            PH_SKIP_PRE, PH_SKIP_FMT, PH_SKIP_MID:
            begin
                if (fc_reg <= 32'd1)
                begin
                    fc_next    = 32'd0;
                    phase_next = (phase_reg == PH_SKIP_PRE) ? PH_FMT_HDR : PH_DATA_HDR;
                end
                else
                begin
                    fc_next = fc_reg - 32'd1;
                end
            end
            PH_FMT_BODY:
            begin
                case (fc_reg[3:0])
                    4'd2:    chan_next[7:0]   = b;
                    4'd3:    chan_next[15:8]  = b;
                    4'd4:    rate_next[7:0]   = b;
                    4'd5:    rate_next[15:8]  = b;
                    4'd6:    rate_next[23:16] = b;
                    4'd7:    rate_next[31:24] = b;
                    4'd14:   bits_next[7:0]   = b;
                    4'd15:   bits_next[15:8]  = b;
                    default: ;
                endcase
                fc_next = fc_reg + 32'd1;
                if (fc_next >= rwhp_pkg::FMT_READ_BYTES)
                begin
                    if (size_reg > rwhp_pkg::FMT_READ_BYTES)
                    begin
                        phase_next = PH_SKIP_FMT;
                        fc_next    = size_reg - rwhp_pkg::FMT_READ_BYTES;
                    end
                    else
                    begin
                        phase_next = PH_DATA_HDR;
                        fc_next    = 32'd0;
                    end
                end
            end
            PH_DATA:
            begin
                dvalid = 1'b1;
                dout   = b;
                if (fc_reg <= 32'd1)
                begin
                    fc_next    = 32'd0;
                    dlast      = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    fc_next = fc_reg - 32'd1;
                end
            end
            default: ;
        endcase

        // end of stream
        if (item.eos)
        begin
            if (phase_next == PH_HEADER)
            begin
                phase_next = PH_BAD;
            end
            else if (phase_next == PH_DATA)
            begin
                if (dvalid)
                begin
                    dlast = 1'b1;
                end
                phase_next = PH_DONE;
            end
            else if (phase_next < PH_DATA)
            begin
                phase_next = PH_NODATA;
            end
        end

        case (phase_next)
            PH_DATA:   st = rwhp_pkg::ST_IN_DATA;
            PH_DONE:   st = rwhp_pkg::ST_DONE;
            PH_BAD:    st = rwhp_pkg::ST_BAD_HDR;
            PH_NODATA: st = rwhp_pkg::ST_NO_DATA;
            default:   st = rwhp_pkg::ST_PARSING;
        endcase

        res_next.status        = st;
        res_next.data_valid    = dvalid;
        res_next.data_out      = dout;
        res_next.data_last     = dlast;
        res_next.channel_count = chan_next;
        res_next.sample_rate   = rate_next;
        res_next.sample_bits   = bits_next;
        res_next.data_length   = len_next;

        if (item_pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fc_reg        <= '0;
            id_reg        <= '0;
            size_reg      <= '0;
            bad_reg       <= 1'b0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (item_pop)
            begin
                phase_reg <= phase_next;
                fc_reg    <= fc_next;
                id_reg    <= id_next;
                size_reg  <= size_next;
                bad_reg   <= bad_next;
                chan_reg  <= chan_next;
                rate_reg  <= rate_next;
                bits_reg  <= bits_next;
                len_reg   <= len_next;
                res_reg   <= res_next;
            end
        end
    end

endmodule

// File: tb/rwhp_checker.sv
// ----------------------------------------------------------------------------
// rwhp_checker
// watches both channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module rwhp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_stream,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic        data_valid,
    input  logic [7:0]  data_out,
    input  logic        data_last,
    input  logic [15:0] channel_count,
    input  logic [31:0] sample_rate,
    input  logic [15:0] sample_bits,
    input  logic [31:0] data_length,
    output int          error_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        P_HEADER,
        P_FMT_HDR,
        P_SKIP_PRE,
        P_FMT_BODY,
        P_SKIP_FMT,
        P_DATA_HDR,
        P_SKIP_MID,
        P_DATA,
        P_DONE,
        P_BAD,
        P_NODATA
    } parse_phase_t;

    parse_phase_t      pstate;
    logic [31:0]       fld_cnt;
    logic [31:0]       id_sr;
    logic [31:0]       size_sr;
    logic              hdr_bad;
    logic [15:0]       chan_q;
    logic [31:0]       rate_q;
    logic [15:0]       bits_q;
    logic [31:0]       len_q;
    rwhp_pkg::result_t expected_q[$];
    int                err_cnt;

    // count down one skipped body byte
    function automatic void skip_one(input parse_phase_t nxt);
        if (fld_cnt <= 1)
        begin
            fld_cnt = 0;
            pstate  = nxt;
        end
        else
        begin
            fld_cnt = fld_cnt - 1;
        end
    endfunction

    // id big-endian, size little-endian; high once all 8 bytes are in
    function automatic bit chunk_hdr_byte(input logic [7:0] b);
        if (fld_cnt < 4)
            id_sr = {id_sr[23:0], b};
        else
            size_sr = {b, size_sr[31:8]};
        fld_cnt = fld_cnt + 1;
        if (fld_cnt >= 8)
        begin
            fld_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic rwhp_pkg::result_t predict_byte(input logic [7:0] b,
                                                       input logic eos);
        rwhp_pkg::result_t r;
        logic [31:0]       k;
        r = '0;
        case (pstate)
            P_HEADER:
            begin
                id_sr = {id_sr[23:0], b};
                if (fld_cnt == 3 && id_sr != rwhp_pkg::ID_RIFF)
                    hdr_bad = 1'b1;
                if (fld_cnt >= rwhp_pkg::HEADER_BYTES - 1)
                begin
                    if (id_sr != rwhp_pkg::ID_WAVE)
                        hdr_bad = 1'b1;
                    fld_cnt = 0;
                    pstate  = hdr_bad ? P_BAD : P_FMT_HDR;
                end
                else
                begin
                    fld_cnt = fld_cnt + 1;
                end
            end
            P_FMT_HDR:
            begin
                if (chunk_hdr_byte(b))
                begin
                    if (id_sr == rwhp_pkg::ID_FMT)
                    begin
                        pstate = P_FMT_BODY;
                    end
                    else if (size_sr != 0)
                    begin
                        pstate  = P_SKIP_PRE;
                        fld_cnt = size_sr;
                    end
                end
            end
            P_SKIP_PRE: skip_one(P_FMT_HDR);
            P_FMT_BODY:
            begin
                k = fld_cnt;
                if (k == 2)
                    chan_q[7:0] = b;
                else if (k == 3)
                    chan_q[15:8] = b;
                else if (k >= 4 && k <= 7)
                    rate_q[8 * (k - 4) +: 8] = b;
                else if (k == 14)
                    bits_q[7:0] = b;
                else if (k == 15)
                    bits_q[15:8] = b;
                fld_cnt = fld_cnt + 1;
                if (fld_cnt >= rwhp_pkg::FMT_READ_BYTES)
                begin
                    if (size_sr > rwhp_pkg::FMT_READ_BYTES)
                    begin
                        pstate  = P_SKIP_FMT;
                        fld_cnt = size_sr - rwhp_pkg::FMT_READ_BYTES;
                    end
                    else
                    begin
                        pstate  = P_DATA_HDR;
                        fld_cnt = 0;
                    end
                end
            end
            P_SKIP_FMT: skip_one(P_DATA_HDR);
            P_DATA_HDR:
            begin
                if (chunk_hdr_byte(b))
                begin
                    if (id_sr == rwhp_pkg::ID_DATA)
                    begin
                        len_q = size_sr;
                        if (size_sr == 0)
                        begin
                            pstate = P_DONE;
                        end
                        else
                        begin
                            pstate  = P_DATA;
                            fld_cnt = size_sr;
                        end
                    end
                    else if (size_sr != 0)
                    begin
                        pstate  = P_SKIP_MID;
                        fld_cnt = size_sr;
                    end
                end
            end
            P_SKIP_MID: skip_one(P_DATA_HDR);
            P_DATA:
            begin
                r.data_valid = 1'b1;
                r.data_out   = b;
                if (fld_cnt <= 1)
                begin
                    fld_cnt     = 0;
                    r.data_last = 1'b1;
                    pstate      = P_DONE;
                end
                else
                begin
                    fld_cnt = fld_cnt - 1;
                end
            end
            default: ;
        endcase

        if (eos)
        begin
            if (pstate == P_HEADER)
            begin
                pstate = P_BAD;
            end
            else if (pstate == P_DATA)
            begin
                if (r.data_valid)
                    r.data_last = 1'b1;
                pstate = P_DONE;
            end
            else if (pstate < P_DATA)
            begin
                pstate = P_NODATA;
            end
        end

        case (pstate)
            P_DATA:   r.status = rwhp_pkg::ST_IN_DATA;
            P_DONE:   r.status = rwhp_pkg::ST_DONE;
            P_BAD:    r.status = rwhp_pkg::ST_BAD_HDR;
            P_NODATA: r.status = rwhp_pkg::ST_NO_DATA;
            default:  r.status = rwhp_pkg::ST_PARSING;
        endcase
        r.channel_count = chan_q;
        r.sample_rate   = rate_q;
        r.sample_bits   = bits_q;
        r.data_length   = len_q;
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, fname, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rwhp_pkg::result_t want;
        if (!rst_n)
        begin
            pstate  = P_HEADER;
            fld_cnt = '0;
            id_sr   = '0;
            size_sr = '0;
            hdr_bad = 1'b0;
            chan_q  = '0;
            rate_q  = '0;
            bits_q  = '0;
            len_q   = '0;
            err_cnt = 0;
            expected_q.delete();
            pending     <= 0;
            error_count <= 0;
        end
        else
        begin
            // input transaction: predict its one result
            if (in_valid && in_ready)
                expected_q.push_back(predict_byte(in_byte, end_of_stream));
            // output transaction: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, status %0d",
                             $time, status);
                    err_cnt++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("data_valid", 32'(want.data_valid),
                                  32'(data_valid));
                    compare_field("data_out", 32'(want.data_out), 32'(data_out));
                    compare_field("data_last", 32'(want.data_last),
                                  32'(data_last));
                    compare_field("channel_count", 32'(want.channel_count),
                                  32'(channel_count));
                    compare_field("sample_rate", want.sample_rate, sample_rate);
                    compare_field("sample_bits", 32'(want.sample_bits),
                                  32'(sample_bits));
                    compare_field("data_length", want.data_length, data_length);
                end
            end
            pending     <= expected_q.size();
            error_count <= err_cnt;
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// feeds one wav file built at random through the parser and gives the verdict
// ----------------------------------------------------------------------------
// the file walks every parse phase: riff/wave header, skipped chunks before
// fmt (zero size, a data id, near-miss ids), fmt with a short, exact or long
// body, skipped chunks after fmt (a second fmt, zero size, near-miss data
// id), then a long data chunk ending either on its last byte, past its end or
// inside its body. a few bytes after the end check that they are ignored.
// the checker predicts and compares; this module only drives and decides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction at all
    localparam int HOLD_CYCLES    = 60;     // long receiver hold-off
    localparam int DRAIN_CYCLES   = 20;     // well past the result latency

    // idle percentages per stimulus phase: sender light, then heavy, then none
    localparam int SEND_IDLE[3] = '{8, 61, 0};
    localparam int RECV_IDLE[3] = '{61, 8, 0};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        data_valid;
    logic [7:0]  data_out;
    logic        data_last;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;

    int              error_count;
    int              pending;
    int              idle_mode;
    int              out_seen;
    int              hold_at;
    int              quiet_cycles;
    rwhp_pkg::item_t file_q[$];

    riff_wave_header_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_valid    (data_valid),
        .data_out      (data_out),
        .data_last     (data_last),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .sample_bits   (sample_bits),
        .data_length   (data_length)
    );

    rwhp_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_valid    (data_valid),
        .data_out      (data_out),
        .data_last     (data_last),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .sample_bits   (sample_bits),
        .data_length   (data_length),
        .error_count   (error_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random value with the extremes weighted in
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        rwhp_pkg::item_t it;
        it.data = b;
        it.eos  = 1'b0;
        file_q.push_back(it);
    endfunction

    // chunk ids go out most significant byte first
    function automatic void push_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--)
            push_byte(id[8 * i +: 8]);
    endfunction

    // sizes and fmt fields are little-endian
    function automatic void push_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            push_byte(v[8 * i +: 8]);
    endfunction

    function automatic void push_body(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'(rand_word()));
    endfunction

    // header plus a random body that the parser is expected to skip
    function automatic void push_chunk(input logic [31:0] id, input int n);
        push_id(id);
        push_le(n, 4);
        push_body(n);
    endfunction

    // random id that is none of the two the parser looks for
    function automatic logic [31:0] other_id();
        logic [31:0] id;
        id = $urandom;
        if (id == rwhp_pkg::ID_FMT || id == rwhp_pkg::ID_DATA)
            id = id ^ 32'h0000_0100;
        return id;
    endfunction

    // ------------------------------------------------------------------------
    // reset, sender and verdict
    // ------------------------------------------------------------------------
    initial
    begin : sender
        int          fmt_size;
        int          body_n;
        int          end_mode;
        int          n_items;
        logic [31:0] len;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        end_of_stream = 1'b0;
        idle_mode     = 0;

        // riff/wave header, riff size of any value
        push_id(rwhp_pkg::ID_RIFF);
        push_le(rand_word(), 4);
        push_id(rwhp_pkg::ID_WAVE);

        // chunks before fmt: zero size, a data chunk, near misses, random ids
        push_chunk(32'h4A55_4E4B, 0);
        push_chunk(rwhp_pkg::ID_DATA, 3);
        push_chunk(rwhp_pkg::ID_FMT ^ (32'h1 << $urandom_range(0, 31)),
                   $urandom_range(1, 6));
        repeat ($urandom_range(1, 3))
            push_chunk(other_id(), $urandom_range(0, 24));

        // fmt chunk: short, exact or long body
        case ($urandom_range(0, 3))
            0:       fmt_size = $urandom_range(0, 15);
            1:       fmt_size = 16;
            default: fmt_size = $urandom_range(17, 40);
        endcase
        push_id(rwhp_pkg::ID_FMT);
        push_le(fmt_size, 4);
        push_le(rand_word(), 2);    // format tag, not read
        push_le(rand_word(), 2);    // channels
        push_le(rand_word(), 4);    // sample rate
        push_body(6);               // byte rate and block align, not read
        push_le(rand_word(), 2);    // bits per sample
        if (fmt_size > 16)
            push_body(fmt_size - 16);

        // chunks after fmt: second fmt, zero size, near-miss data id
        push_chunk(rwhp_pkg::ID_FMT, 4);
        push_chunk(32'h4C49_5354, 0);
        push_chunk(rwhp_pkg::ID_DATA ^ (32'h1 << $urandom_range(0, 31)),
                   $urandom_range(1, 5));
        repeat ($urandom_range(0, 2))
            push_chunk(other_id(), $urandom_range(0, 16));

        // data chunk and how the stream ends
        body_n   = $urandom_range(760, 820);
        end_mode = $urandom_range(0, 2);
        if (end_mode == 2)
            len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : body_n + $urandom_range(1, 500);
        else
            len = body_n;
        push_id(rwhp_pkg::ID_DATA);
        push_le(len, 4);
        push_body(body_n);
        if (end_mode == 1)
            push_byte(8'(rand_word()));
        file_q[file_q.size() - 1].eos = 1'b1;

        // bytes after the end only repeat the final result
        repeat (4)
        begin
            push_byte(8'(rand_word()));
            file_q[file_q.size() - 1].eos = 1'($urandom_range(0, 1));
        end

        n_items = file_q.size();
        hold_at = (2 * n_items) / 3 + 40;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < n_items; i++)
        begin
            idle_mode = (i < n_items / 3) ? 0 : (i < (2 * n_items) / 3) ? 1 : 2;
            while ($urandom_range(0, 99) < SEND_IDLE[idle_mode])
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            in_byte       <= file_q[i].data;
            end_of_stream <= file_q[i].eos;
            // hold the transaction until it is taken
            do
                @(posedge clk);
            while (!in_ready);
        end
        in_valid <= 1'b0;

        // let the last predictions land, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off so the queue backs up
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && idle_mode == 2 && out_seen >= hold_at)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_mode]);
                @(posedge clk);
            end
        end
    end

    // count taken results for the hold-off trigger
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_seen <= 0;
        else if (out_valid && out_ready)
            out_seen <= out_seen + 1;
    end

    // watchdog: ends the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
